>>> rtl/core/dctq_pkg.sv
// ----------------------------------------------------------------------------
// dctq_pkg
// Shared types and constants for the deferred-commit timer queue.
// ----------------------------------------------------------------------------
package dctq_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int PEND_DEPTH  = 8;
    localparam int SEQ_BITS    = 16;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_DEL    = 2'd1;
    localparam logic [1:0] OP_UPD    = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [1:0] EV_ADD_ACK = 2'd0;
    localparam logic [1:0] EV_DEL_ACK = 2'd1;
    localparam logic [1:0] EV_FIRED   = 2'd2;
    localparam logic [1:0] EV_UPD_END = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_DUP  = 2'd2;

    typedef struct packed {
        logic        valid;
        logic [47:0] expire;
        logic [31:0] conn;
        logic [63:0] user;
    } entry_t;

    typedef enum logic [1:0] {
        CELL_NOP,
        CELL_INS,
        CELL_REM
    } cell_op_t;

    typedef struct packed {
        cell_op_t    op;
        logic        hit;
        logic [47:0] expire;
        logic [31:0] conn;
        logic [63:0] user;
    } cell_cmd_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] conn_id;
        logic [47:0] expire_ms;
        logic [63:0] user_data;
        logic [47:0] now_ms;
    } req_beat_t;

    typedef struct packed {
        logic [1:0]  event_kind;
        logic [31:0] conn_id_out;
        logic [47:0] expire_out;
        logic [63:0] user_data_out;
        logic [63:0] timer_id;
        logic [1:0]  status;
        logic        last;
    } rsp_beat_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIRE,
        S_DEL,
        S_ADD,
        S_DONE
    } state_t;

endpackage

>>> rtl/core/dctq_cell.sv
// ----------------------------------------------------------------------------
// dctq_cell
// One slot of a sorted chain: keeps, takes the broadcast entry, or takes a
// neighbor's entry so the chain stays packed and in ascending key order.
// ----------------------------------------------------------------------------
module dctq_cell import dctq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cell_cmd_t cmd,
    input  entry_t    prev,
    input  logic      prev_less,
    input  entry_t    next,
    output entry_t    self,
    output logic      less,
    output logic      eq
);

    logic        valid_reg, valid_next;
    logic [47:0] expire_reg, expire_next;
    logic [31:0] conn_reg, conn_next;
    logic [63:0] user_reg, user_next;

    assign self = '{valid: valid_reg, expire: expire_reg, conn: conn_reg, user: user_reg};
    assign less = valid_reg && ({expire_reg, conn_reg} < {cmd.expire, cmd.conn});
    assign eq   = valid_reg && (expire_reg == cmd.expire) && (conn_reg == cmd.conn);

    always_comb
    begin
        valid_next  = valid_reg;
        expire_next = expire_reg;
        conn_next   = conn_reg;
        user_next   = user_reg;
        unique case (cmd.op)
            CELL_INS:
            begin
                if (less)
                begin
                    valid_next = valid_reg;
                end
                else if (prev_less)
                begin
                    valid_next  = 1'b1;
                    expire_next = cmd.expire;
                    conn_next   = cmd.conn;
                    user_next   = cmd.user;
                end
                else
                begin
                    valid_next  = prev.valid;
                    expire_next = prev.expire;
                    conn_next   = prev.conn;
                    user_next   = prev.user;
                end
            end
            CELL_REM:
            begin
                // everything at or above the removed key moves down one
                if (cmd.hit && valid_reg && !less)
                begin
                    valid_next  = next.valid;
                    expire_next = next.expire;
                    conn_next   = next.conn;
                    user_next   = next.user;
                end
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        expire_reg <= expire_next;
        conn_reg   <= conn_next;
        user_reg   <= user_next;
    end

endmodule

>>> rtl/core/deferred_commit_timer_queue.sv
// ----------------------------------------------------------------------------
// deferred_commit_timer_queue
// Timer table with staged adds and deletes, committed on an update.
// ----------------------------------------------------------------------------
// Usage:
//   req (valid/stall) carries one request beat: add, delete or update.
//   rsp (valid/stall) carries result beats; last marks the final one.
//   Add and delete give one beat, in the cycle after accept.
//   Update gives one beat per fired timer, then an update-done beat.
//   An update first pops the fired timers one per cycle from the head of
//   the sorted table chain, then drains the staged deletes and then the
//   staged adds one per cycle from the head of each chain, and last sends
//   the update-done beat.
//   Operation code 3 is accepted and gives no beat.
//   One request is in work at a time; req_stall is high while an update
//   runs or while the result register is full and stalled.
//   A stall on rsp holds the result register and pauses the fire and done
//   steps of an update.
//   Reset clears all valid bits and the sequence counter; no sweep needed.
// ----------------------------------------------------------------------------
module deferred_commit_timer_queue import dctq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  req_beat_t req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_beat_t rsp
);

    state_t state_reg, state_next;
    logic [SEQ_BITS-1:0] seq_reg, seq_next;
    logic [47:0] now_reg, now_next;
    logic        full_reg, full_next;
    logic        rsp_valid_reg, rsp_valid_next;
    rsp_beat_t   rsp_reg, rsp_next;

    cell_cmd_t tbl_cmd, add_cmd, del_cmd;
    entry_t    tbl [TABLE_DEPTH];
    entry_t    add [PEND_DEPTH];
    entry_t    del [PEND_DEPTH];
    logic [TABLE_DEPTH-1:0] tbl_less, tbl_eq;
    logic [PEND_DEPTH-1:0]  add_less, add_eq, del_less, del_eq;
    logic tbl_hit, add_hit, del_hit, out_free, req_take;

    assign tbl_hit = |tbl_eq;
    assign add_hit = |add_eq;
    assign del_hit = |del_eq;

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++)
        begin : g_tbl
            dctq_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .cmd       (tbl_cmd),
                .prev      ((g == 0) ? entry_t'('0) : tbl[(g == 0) ? 0 : g-1]),
                .prev_less ((g == 0) ? 1'b1 : tbl_less[(g == 0) ? 0 : g-1]),
                .next      ((g == TABLE_DEPTH-1) ? entry_t'('0)
                                                 : tbl[(g == TABLE_DEPTH-1) ? g : g+1]),
                .self      (tbl[g]),
                .less      (tbl_less[g]),
                .eq        (tbl_eq[g])
            );
        end
        for (g = 0; g < PEND_DEPTH; g++)
        begin : g_pend
            dctq_cell u_add (
                .clk       (clk),
                .rst_n     (rst_n),
                .cmd       (add_cmd),
                .prev      ((g == 0) ? entry_t'('0) : add[(g == 0) ? 0 : g-1]),
                .prev_less ((g == 0) ? 1'b1 : add_less[(g == 0) ? 0 : g-1]),
                .next      ((g == PEND_DEPTH-1) ? entry_t'('0)
                                                : add[(g == PEND_DEPTH-1) ? g : g+1]),
                .self      (add[g]),
                .less      (add_less[g]),
                .eq        (add_eq[g])
            );
            dctq_cell u_del (
                .clk       (clk),
                .rst_n     (rst_n),
                .cmd       (del_cmd),
                .prev      ((g == 0) ? entry_t'('0) : del[(g == 0) ? 0 : g-1]),
                .prev_less ((g == 0) ? 1'b1 : del_less[(g == 0) ? 0 : g-1]),
                .next      ((g == PEND_DEPTH-1) ? entry_t'('0)
                                                : del[(g == PEND_DEPTH-1) ? g : g+1]),
                .self      (del[g]),
                .less      (del_less[g]),
                .eq        (del_eq[g])
            );
        end
    endgenerate

    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign req_stall = (state_reg != S_IDLE) || !out_free;
    assign req_take  = req_valid && !req_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next     = state_reg;
        seq_next       = seq_reg;
        now_next       = now_reg;
        full_next      = full_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_stall ? rsp_valid_reg : 1'b0;
        tbl_cmd        = '{op: CELL_NOP, hit: 1'b0, expire: tbl[0].expire,
                           conn: tbl[0].conn, user: tbl[0].user};
        add_cmd        = '{op: CELL_NOP, hit: 1'b0, expire: req.expire_ms,
                           conn: req.conn_id, user: req.user_data};
        del_cmd        = '{op: CELL_NOP, hit: 1'b0, expire: req.expire_ms,
                           conn: req.conn_id, user: 64'd0};
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_take)
                begin
                    rsp_next = '{event_kind: EV_ADD_ACK, conn_id_out: req.conn_id,
                                 expire_out: req.expire_ms, user_data_out: 64'd0,
                                 timer_id: 64'd0, status: ST_OK, last: 1'b1};
                    if (req.operation == OP_ADD)
                    begin
                        rsp_valid_next         = 1'b1;
                        rsp_next.user_data_out = req.user_data;
                        rsp_next.timer_id      = (64'(req.expire_ms) << SEQ_BITS)
                                                 | 64'(seq_reg);
                        seq_next               = seq_reg + 1'b1;
                        if (add_hit)
                            rsp_next.status = ST_DUP;
                        else if (add[PEND_DEPTH-1].valid)
                            rsp_next.status = ST_FULL;
                        else
                            add_cmd.op = CELL_INS;
                    end
                    else if (req.operation == OP_DEL)
                    begin
                        rsp_valid_next      = 1'b1;
                        rsp_next.event_kind = EV_DEL_ACK;
                        if (!del_hit)
                        begin
                            if (del[PEND_DEPTH-1].valid)
                                rsp_next.status = ST_FULL;
                            else
                                del_cmd.op = CELL_INS;
                        end
                    end
                    else if (req.operation == OP_UPD)
                    begin
                        now_next   = req.now_ms;
                        full_next  = 1'b0;
                        state_next = S_FIRE;
                    end
                end
            end
            S_FIRE:
            begin
                if (tbl[0].valid && (tbl[0].expire <= now_reg))
                begin
                    if (out_free)
                    begin
                        rsp_valid_next = 1'b1;
                        rsp_next = '{event_kind: EV_FIRED, conn_id_out: tbl[0].conn,
                                     expire_out: tbl[0].expire,
                                     user_data_out: tbl[0].user, timer_id: 64'd0,
                                     status: ST_OK, last: 1'b0};
                        tbl_cmd.op  = CELL_REM;
                        tbl_cmd.hit = 1'b1;
                    end
                end
                else
                begin
                    state_next = S_DEL;
                end
            end
            S_DEL:
            begin
                if (del[0].valid)
                begin
                    tbl_cmd.expire = del[0].expire;
                    tbl_cmd.conn   = del[0].conn;
                    tbl_cmd.op     = CELL_REM;
                    tbl_cmd.hit    = tbl_hit;
                    del_cmd.expire = del[0].expire;
                    del_cmd.conn   = del[0].conn;
                    del_cmd.op     = CELL_REM;
                    del_cmd.hit    = 1'b1;
                end
                else
                begin
                    state_next = S_ADD;
                end
            end
            S_ADD:
            begin
                if (add[0].valid)
                begin
                    tbl_cmd.expire = add[0].expire;
                    tbl_cmd.conn   = add[0].conn;
                    tbl_cmd.user   = add[0].user;
                    if (!tbl_hit)
                    begin
                        if (tbl[TABLE_DEPTH-1].valid)
                            full_next = 1'b1;
                        else
                            tbl_cmd.op = CELL_INS;
                    end
                    add_cmd.expire = add[0].expire;
                    add_cmd.conn   = add[0].conn;
                    add_cmd.op     = CELL_REM;
                    add_cmd.hit    = 1'b1;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next = '{event_kind: EV_UPD_END, conn_id_out: 32'd0,
                                 expire_out: 48'd0, user_data_out: 64'd0,
                                 timer_id: 64'd0,
                                 status: full_reg ? ST_FULL : ST_OK, last: 1'b1};
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            seq_reg       <= '0;
            full_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            seq_reg       <= seq_next;
            full_reg      <= full_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg <= now_next;
        rsp_reg <= rsp_next;
    end

endmodule

>>> sim/tb_deferred_commit_timer_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_deferred_commit_timer_queue
// Drives add, delete and update requests into the timer queue, keeps a
// shadow timer table with staged adds and deletes, and checks every result
// beat against the predicted sequence. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_deferred_commit_timer_queue;
    import dctq_pkg::*;

    class timer_scoreboard;
        logic [47:0] tbl_exp [TABLE_DEPTH];
        logic [31:0] tbl_conn [TABLE_DEPTH];
        logic [63:0] tbl_user [TABLE_DEPTH];
        bit          tbl_vld [TABLE_DEPTH];
        logic [47:0] add_exp [PEND_DEPTH];
        logic [31:0] add_conn [PEND_DEPTH];
        logic [63:0] add_user [PEND_DEPTH];
        bit          add_vld [PEND_DEPTH];
        logic [47:0] del_exp [PEND_DEPTH];
        logic [31:0] del_conn [PEND_DEPTH];
        bit          del_vld [PEND_DEPTH];
        logic [SEQ_BITS-1:0] seq_num;
        rsp_beat_t   pending_rsp [$];
        int          errors;

        function new();
            for (int i = 0; i < TABLE_DEPTH; i++) tbl_vld[i] = 0;
            for (int i = 0; i < PEND_DEPTH; i++) begin
                add_vld[i] = 0;
                del_vld[i] = 0;
            end
            seq_num = '0;
            errors = 0;
        endfunction

        function bit key_lt(logic [47:0] e1, logic [31:0] c1, logic [47:0] e2,
                            logic [31:0] c2);
            return (e1 < e2) || (e1 == e2 && c1 < c2);
        endfunction

        function void push(logic [1:0] kind, logic [31:0] c, logic [47:0] e,
                           logic [63:0] u, logic [63:0] tid, logic [1:0] st,
                           logic lst);
            rsp_beat_t r;
            r.event_kind = kind;
            r.conn_id_out = c;
            r.expire_out = e;
            r.user_data_out = u;
            r.timer_id = tid;
            r.status = st;
            r.last = lst;
            pending_rsp.push_back(r);
        endfunction

        function void note_request(req_beat_t q);
            logic [1:0] st;
            int fs;
            int best;
            bit hit;
            st = ST_OK;
            fs = -1;
            hit = 0;
            case (q.operation)
                OP_ADD:
                begin
                    for (int i = 0; i < PEND_DEPTH; i++) begin
                        if (add_vld[i]) begin
                            if (add_exp[i] == q.expire_ms && add_conn[i] == q.conn_id)
                                st = ST_DUP;
                        end
                        else if (fs < 0) fs = i;
                    end
                    if (st == ST_OK) begin
                        if (fs < 0) st = ST_FULL;
                        else
                        begin
                            add_vld[fs] = 1;
                            add_exp[fs] = q.expire_ms;
                            add_conn[fs] = q.conn_id;
                            add_user[fs] = q.user_data;
                        end
                    end
                    push(EV_ADD_ACK, q.conn_id, q.expire_ms, q.user_data,
                         {q.expire_ms, seq_num}, st, 1'b1);
                    seq_num = seq_num + 1'b1;
                end
                OP_DEL:
                begin
                    for (int i = 0; i < PEND_DEPTH; i++) begin
                        if (del_vld[i]) begin
                            if (del_exp[i] == q.expire_ms && del_conn[i] == q.conn_id)
                                hit = 1;
                        end
                        else if (fs < 0) fs = i;
                    end
                    if (!hit) begin
                        if (fs < 0) st = ST_FULL;
                        else
                        begin
                            del_vld[fs] = 1;
                            del_exp[fs] = q.expire_ms;
                            del_conn[fs] = q.conn_id;
                        end
                    end
                    push(EV_DEL_ACK, q.conn_id, q.expire_ms, '0, '0, st, 1'b1);
                end
                OP_UPD:
                begin
                    forever begin
                        best = -1;
                        for (int i = 0; i < TABLE_DEPTH; i++)
                            if (tbl_vld[i] && tbl_exp[i] <= q.now_ms &&
                                (best < 0 || key_lt(tbl_exp[i], tbl_conn[i],
                                                    tbl_exp[best], tbl_conn[best])))
                                best = i;
                        if (best < 0) break;
                        push(EV_FIRED, tbl_conn[best], tbl_exp[best], tbl_user[best],
                             '0, ST_OK, 1'b0);
                        tbl_vld[best] = 0;
                    end
                    for (int j = 0; j < PEND_DEPTH; j++) begin
                        if (del_vld[j])
                            for (int i = 0; i < TABLE_DEPTH; i++)
                                if (tbl_vld[i] && tbl_exp[i] == del_exp[j] &&
                                    tbl_conn[i] == del_conn[j])
                                    tbl_vld[i] = 0;
                        del_vld[j] = 0;
                    end
                    forever begin
                        best = -1;
                        hit = 0;
                        fs = -1;
                        for (int j = 0; j < PEND_DEPTH; j++)
                            if (add_vld[j] && (best < 0 || key_lt(add_exp[j], add_conn[j],
                                               add_exp[best], add_conn[best])))
                                best = j;
                        if (best < 0) break;
                        for (int i = 0; i < TABLE_DEPTH; i++) begin
                            if (tbl_vld[i]) begin
                                if (tbl_exp[i] == add_exp[best] && tbl_conn[i] == add_conn[best])
                                    hit = 1;
                            end
                            else if (fs < 0) fs = i;
                        end
                        if (!hit) begin
                            if (fs < 0) st = ST_FULL;
                            else
                            begin
                                tbl_vld[fs] = 1;
                                tbl_exp[fs] = add_exp[best];
                                tbl_conn[fs] = add_conn[best];
                                tbl_user[fs] = add_user[best];
                            end
                        end
                        add_vld[best] = 0;
                    end
                    push(EV_UPD_END, '0, '0, '0, '0, st, 1'b1);
                end
                default: ;
            endcase
        endfunction

        function void check_result(rsp_beat_t a);
            rsp_beat_t x;
            if (pending_rsp.size() == 0) begin
                $error("unexpected result beat %p", a);
                errors++;
                return;
            end
            x = pending_rsp.pop_front();
            if (a.event_kind !== x.event_kind) begin
                $error("event_kind exp %0d got %0d", x.event_kind, a.event_kind);
                errors++;
            end
            if (a.conn_id_out !== x.conn_id_out) begin
                $error("conn_id_out exp %h got %h", x.conn_id_out, a.conn_id_out);
                errors++;
            end
            if (a.expire_out !== x.expire_out) begin
                $error("expire_out exp %h got %h", x.expire_out, a.expire_out);
                errors++;
            end
            if (a.user_data_out !== x.user_data_out) begin
                $error("user_data_out exp %h got %h", x.user_data_out, a.user_data_out);
                errors++;
            end
            if (a.timer_id !== x.timer_id) begin
                $error("timer_id exp %h got %h", x.timer_id, a.timer_id);
                errors++;
            end
            if (a.status !== x.status) begin
                $error("status exp %0d got %0d", x.status, a.status);
                errors++;
            end
            if (a.last !== x.last) begin
                $error("last exp %0d got %0d", x.last, a.last);
                errors++;
            end
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      req_valid;
    logic      req_stall;
    req_beat_t req;
    logic      rsp_valid;
    logic      rsp_stall;
    rsp_beat_t rsp;

    timer_scoreboard sb;
    bit idle_free;
    // small key pool so duplicates, deletes and firing actually collide
    logic [47:0] exp_pool [8];
    logic [31:0] conn_pool [4];

    deferred_commit_timer_queue u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk)
    begin
        if (rst_n && req_valid && !req_stall)
            sb.note_request(req);
        if (rst_n && rsp_valid && !rsp_stall)
            sb.check_result(rsp);
    end

    always @(negedge clk)
    begin
        if (!rst_n) rsp_stall <= 1'b0;
        else rsp_stall <= !idle_free && ($urandom_range(99) < 10);
    end

    // valid stays high after the accepting edge; the next call replaces or drops it, or req_idle drops it
    task automatic send_beat(req_beat_t q);
        @(negedge clk);
        while (!idle_free && $urandom_range(99) < 10)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req <= q;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall) @(posedge clk);
    endtask

    task automatic req_idle();
        @(negedge clk);
        req_valid <= 1'b0;
    endtask

    task automatic send_op(logic [1:0] op, logic [31:0] c, logic [47:0] e,
                           logic [63:0] u, logic [47:0] n);
        req_beat_t q;
        q.operation = op;
        q.conn_id = c;
        q.expire_ms = e;
        q.user_data = u;
        q.now_ms = n;
        send_beat(q);
    endtask

    task automatic send_random_pooled();
        int r;
        logic [47:0] e;
        r = $urandom_range(99);
        e = exp_pool[$urandom_range(7)];
        if (r < 50)
            send_op(OP_ADD, conn_pool[$urandom_range(3)], e,
                    {$urandom, $urandom}, 48'({$urandom, $urandom}));
        else if (r < 70)
            send_op(OP_DEL, conn_pool[$urandom_range(3)], e,
                    {$urandom, $urandom}, 48'({$urandom, $urandom}));
        else if (r < 95)
            send_op(OP_UPD, $urandom, 48'({$urandom, $urandom}),
                    {$urandom, $urandom}, exp_pool[$urandom_range(7)]);
        else
            send_op(OP_UNUSED, $urandom, 48'({$urandom, $urandom}),
                    {$urandom, $urandom}, 48'({$urandom, $urandom}));
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        idle_free = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // extremes, duplicates, same-key add and delete, full stores
        send_op(OP_ADD, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, '1, '0);
        send_op(OP_ADD, 32'h0, 48'h0, '0, '1);
        send_op(OP_ADD, 32'h0, 48'h0, 64'h1234, '0);
        send_op(OP_DEL, 32'h5, 48'h5, '1, '0);
        send_op(OP_DEL, 32'h5, 48'h5, '0, '0);
        send_op(OP_UPD, '1, '1, '1, 48'h0);
        send_op(OP_UPD, '0, '0, '0, 48'h0);
        send_op(OP_DEL, 32'h0, 48'h0, '0, '0);
        send_op(OP_ADD, 32'h0, 48'h0, 64'hAAAA, '0);
        send_op(OP_UNUSED, '1, '1, '1, '1);
        send_op(OP_UPD, '0, '0, '0, 48'h10);
        for (int i = 0; i < 9; i++)
            send_op(OP_ADD, i, 48'h100 + i, {$urandom, $urandom}, '0);
        for (int i = 0; i < 9; i++)
            send_op(OP_DEL, i + 100, 48'h7, '0, '0);
        send_op(OP_UPD, '0, '0, '0, 48'h0);
        for (int k = 0; k < 2; k++)
            for (int i = 0; i < 8; i++)
                send_op(OP_ADD, 32'h40 + i + 8 * k, 48'h200, {$urandom, $urandom}, '0);
        send_op(OP_UPD, '0, '0, '0, 48'h0);
        send_op(OP_UPD, '0, '0, '0, '1);
        req_idle();

        // hold off until every outstanding beat has drained
        while (sb.pending_rsp.size() != 0) @(negedge clk);

        for (int i = 0; i < 8; i++)
            exp_pool[i] = 48'({$urandom, $urandom} >> $urandom_range(47));
        for (int i = 0; i < 4; i++) conn_pool[i] = $urandom;
        for (int n = 0; n < 100; n++) begin
            idle_free = (n >= 60 && n < 90);
            if (n == 50)
                send_op(OP_UPD, '0, '0, '0, '1);
            send_random_pooled();
        end
        req_idle();
        idle_free = 1'b0;

        while (sb.pending_rsp.size() != 0) @(negedge clk);
        repeat (50) @(negedge clk);
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/dctq_pkg.sv
rtl/core/dctq_cell.sv
rtl/core/deferred_commit_timer_queue.sv
sim/tb_deferred_commit_timer_queue.sv
